// ----- rtl/ilie_pkg.sv -----
package ilie_pkg;

   // Storage geometry.
   localparam int CAPACITY   = 64;
   localparam int WORD_W     = 64;
   localparam int IDX_W      = $clog2(CAPACITY);
   localparam int INDEX_W    = 7;
   localparam int COUNT_W    = 7;
   localparam int GROUP_SIZE = 8;
   localparam int GROUPS     = CAPACITY / GROUP_SIZE;

   // Answer to a read outside the list: the double 9999.0.
   localparam logic [WORD_W-1:0] BAD_READ_PATTERN = 64'h40C3_8780_0000_0000;

   typedef enum logic [1:0] {
      MODE_APPEND = 2'd0,
      MODE_READ   = 2'd1,
      MODE_ERASE  = 2'd2,
      MODE_INSERT = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   // What the cells do with one request. An append is an insert at the count.
   typedef enum logic [1:0] {
      OP_HOLD   = 2'd0,
      OP_INSERT = 2'd1,
      OP_ERASE  = 2'd2
   } op_type;

   typedef struct packed {
      op_type            op;
      logic [IDX_W-1:0]  pos;
      logic [WORD_W-1:0] word;
   } cell_cmd_type;

endpackage

// ----- rtl/ilie_cell.sv -----
module ilie_cell (
   input  logic                                  clock,
   input  ilie_pkg::cell_cmd_type                cmd,
   input  logic [ilie_pkg::IDX_W-1:0]            cell_index,
   input  logic [ilie_pkg::WORD_W-1:0]           left_word,
   input  logic [ilie_pkg::WORD_W-1:0]           right_word,
   output logic [ilie_pkg::WORD_W-1:0]           word,
   output logic [ilie_pkg::WORD_W-1:0]           tap
);
   import ilie_pkg::*;

   logic [WORD_W-1:0] word_ff;
   logic [WORD_W-1:0] word_in;

   always_comb begin
      word_in = word_ff;
      case (cmd.op)
         OP_INSERT: begin
            if (cell_index == cmd.pos) begin
               word_in = cmd.word;
            end else if (cell_index > cmd.pos) begin
               word_in = left_word;
            end
         end
         OP_ERASE: begin
            if (cell_index >= cmd.pos) begin
               word_in = right_word;
            end
         end
         default: begin
            word_in = word_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      word_ff <= word_in;
   end

   assign word = word_ff;
   // Only the addressed cell puts its word on the read tap.
   assign tap  = (cell_index == cmd.pos) ? word_ff : '0;

endmodule

// ----- rtl/indexed_list_insert_erase_top.sv -----
// Channel | Direction | Handshake              | Contents
// req     | in        | req_tvalid/req_tready  | tuser: mode; tdata: index, value
// rsp     | out       | rsp_tvalid/rsp_tready  | tdata: read_data, status, count, is_empty
//
// The list lives in a row of 64 cells, so an insert, erase or append is done at the edge
// that accepts its word; a read is caught in a registered OR tree over groups of eight.
// The group ORs and the request's status are registered at acceptance, and the result
// register loads from them once the output is free, so a word is accepted every cycle while
// results flow. Reset clears the count and handshake state but not the cells. A stalled
// result holds one pending request and drops req_tready until the result is taken.
module indexed_list_insert_erase_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // [1:0] mode
   input  logic [71:0] req_tdata,   // [6:0] index, [70:7] value, [71] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata    // [63:0] read_data, [65:64] status,
                                    // [72:66] count, [73] is_empty, [79:74] zero
);
   import ilie_pkg::*;

   logic                accept;
   logic                out_free;
   mode_type            req_mode;
   logic [INDEX_W-1:0]  req_index;
   logic [WORD_W-1:0]   req_value;

   cell_cmd_type        cmd;
   status_type          status_in;
   logic [COUNT_W-1:0]  count_in;
   logic                read_hit_in;
   logic                read_bad_in;

   logic [COUNT_W-1:0]  count_ff;
   logic                pend_ff;
   logic                pend_in;
   logic                read_hit_ff;
   logic                read_bad_ff;
   status_type          status_ff;
   logic [COUNT_W-1:0]  pend_count_ff;

   logic [WORD_W-1:0]   words [CAPACITY];
   logic [WORD_W-1:0]   taps  [CAPACITY];
   logic [WORD_W-1:0]   group_or_in [GROUPS];
   logic [WORD_W-1:0]   group_or_ff [GROUPS];
   logic [WORD_W-1:0]   read_word;
   logic [WORD_W-1:0]   data_out;

   logic                rsp_tvalid_ff;
   logic                rsp_tvalid_in;
   logic [79:0]         rsp_tdata_ff;

   assign req_mode  = mode_type'(req_tuser);
   assign req_index = req_tdata[6:0];
   assign req_value = req_tdata[70:7];

   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   // The pending request frees its slot in the same cycle it moves out.
   assign req_tready = !pend_ff || out_free;
   assign accept     = req_tvalid && req_tready;

   // Request decode against the current count.
   always_comb begin
      cmd.op      = OP_HOLD;
      cmd.pos     = req_index[IDX_W-1:0];
      cmd.word    = req_value;
      status_in   = STATUS_OK;
      count_in    = count_ff;
      read_hit_in = 1'b0;
      read_bad_in = 1'b0;
      case (req_mode)
         MODE_APPEND: begin
            cmd.pos = count_ff[IDX_W-1:0];
            if (count_ff == COUNT_W'(CAPACITY)) begin
               status_in = STATUS_FULL;
            end else begin
               cmd.op   = OP_INSERT;
               count_in = count_ff + COUNT_W'(1);
            end
         end
         MODE_READ: begin
            if (req_index < count_ff) begin
               read_hit_in = 1'b1;
            end else begin
               read_bad_in = 1'b1;
               status_in   = STATUS_RANGE;
            end
         end
         MODE_ERASE: begin
            if (req_index < count_ff) begin
               cmd.op   = OP_ERASE;
               count_in = count_ff - COUNT_W'(1);
            end else begin
               status_in = STATUS_RANGE;
            end
         end
         default: begin
            if (req_index > count_ff) begin
               status_in = STATUS_RANGE;
            end else if (count_ff == COUNT_W'(CAPACITY)) begin
               status_in = STATUS_FULL;
            end else begin
               cmd.op   = OP_INSERT;
               count_in = count_ff + COUNT_W'(1);
            end
         end
      endcase
      // Cells change only on an accepted word.
      if (!accept) begin
         cmd.op = OP_HOLD;
      end
   end

   // The row of cells.
   for (genvar c = 0; c < CAPACITY; c++) begin : g_cell
      logic [WORD_W-1:0] left_word;
      logic [WORD_W-1:0] right_word;
      if (c == 0) begin : g_first
         assign left_word = '0;
      end else begin : g_left
         assign left_word = words[c-1];
      end
      if (c == CAPACITY - 1) begin : g_last
         assign right_word = '0;
      end else begin : g_right
         assign right_word = words[c+1];
      end
      ilie_cell u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .cell_index (IDX_W'(c)),
         .left_word  (left_word),
         .right_word (right_word),
         .word       (words[c]),
         .tap        (taps[c])
      );
   end

   // First level of the read tree: one OR per group of eight cells.
   always_comb begin
      for (int g = 0; g < GROUPS; g++) begin
         group_or_in[g] = '0;
         for (int k = 0; k < GROUP_SIZE; k++) begin
            group_or_in[g] = group_or_in[g] | taps[g*GROUP_SIZE + k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         group_or_ff <= group_or_in;
      end
   end

   always_comb begin
      read_word = '0;
      for (int g = 0; g < GROUPS; g++) begin
         read_word = read_word | group_or_ff[g];
      end
   end

   always_comb begin
      if (read_hit_ff) begin
         data_out = read_word;
      end else if (read_bad_ff) begin
         data_out = BAD_READ_PATTERN;
      end else begin
         data_out = '0;
      end
   end

   // Pending request and element count.
   always_comb begin
      pend_in = pend_ff;
      if (accept) begin
         pend_in = 1'b1;
      end else if (pend_ff && out_free) begin
         pend_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         pend_ff <= pend_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         read_hit_ff   <= read_hit_in;
         read_bad_ff   <= read_bad_in;
         status_ff     <= status_in;
         pend_count_ff <= count_in;
      end
   end

   // Result register.
   assign rsp_tvalid_in = (pend_ff && out_free) || (rsp_tvalid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_ff && out_free) begin
         rsp_tdata_ff <= {6'd0, (pend_count_ff == '0), pend_count_ff,
                          status_ff, data_out};
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   // The count never passes the capacity.
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(CAPACITY))
      else $error("element count above capacity");

   // A stalled pending request is kept until its result can be loaded.
   assert property (@(posedge clock) disable iff (reset)
      pend_ff && !out_free |=> pend_ff)
      else $error("pending request dropped while result stalled");

   // A shifting insert grows the list by exactly one.
   assert property (@(posedge clock) disable iff (reset)
      accept && cmd.op == OP_INSERT |=> count_ff == $past(count_ff) + COUNT_W'(1))
      else $error("insert did not grow the count by one");

   // A shifting erase shrinks the list by exactly one.
   assert property (@(posedge clock) disable iff (reset)
      accept && cmd.op == OP_ERASE |=> count_ff == $past(count_ff) - COUNT_W'(1))
      else $error("erase did not shrink the count by one");

   // The empty flag of a shown result agrees with its count.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid_ff |-> rsp_tdata_ff[73] == (rsp_tdata_ff[72:66] == '0))
      else $error("empty flag disagrees with count");

endmodule

// ----- tb/tb.sv -----
// Self-checking bench for the indexed list block.
// Every request word accepted on the req channel is run through a predictor
// that keeps its own copy of the list (a queue of words) and queues the
// answer the block should give. A separate checker process takes each
// answer word as it leaves the rsp channel and compares it field by field
// with the oldest queued answer.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ilie_pkg::*;

   // A run is stuck when no word has moved on either channel for this many
   // cycles. The longest legal quiet spell is the receiver's long hold-off.
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int HOLD_OFF_CYCLES = 150;

   typedef struct {
      logic [WORD_W-1:0]  read_data;
      status_type         status;
      logic [COUNT_W-1:0] count;
      logic               is_empty;
   } list_answer_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [1:0]  req_tuser;   // [1:0] mode
   logic [71:0] req_tdata;   // [6:0] index, [70:7] value, [71] zero
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [79:0] rsp_tdata;   // [63:0] read_data, [65:64] status,
                             // [72:66] count, [73] is_empty, [79:74] zero

   // The predictor's view of the list, and the answers still to come back.
   logic [WORD_W-1:0] list_words[$];
   list_answer_type   expected_answers[$];

   int  mismatches   = 0;
   int  quiet_cycles = 0;
   // When set, neither side inserts idle cycles between words.
   bit  steady_flow  = 1'b0;
   // A nonzero value asks the receiver to hold off for that many cycles.
   int  hold_request = 0;

   indexed_list_insert_erase_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Work out the answer to one accepted request and update the list copy.
   // An append is refused when full; a bad insert index is reported before
   // a full store is, so an insert past the count on a full list is a range
   // error rather than a full one.
   function automatic void predict_answer(input mode_type mode,
                                          input logic [INDEX_W-1:0] index,
                                          input logic [WORD_W-1:0] value);
      list_answer_type answer;
      int              held;
      held             = list_words.size();
      answer.read_data = '0;
      answer.status    = STATUS_OK;
      case (mode)
         MODE_APPEND: begin
            if (held >= CAPACITY) answer.status = STATUS_FULL;
            else list_words.insert(held, value);
         end
         MODE_READ: begin
            if (int'(index) < held) begin
               answer.read_data = list_words[index];
            end else begin
               answer.read_data = BAD_READ_PATTERN;
               answer.status    = STATUS_RANGE;
            end
         end
         MODE_ERASE: begin
            if (int'(index) < held) list_words.delete(int'(index));
            else answer.status = STATUS_RANGE;
         end
         default: begin
            if (int'(index) > held) answer.status = STATUS_RANGE;
            else if (held >= CAPACITY) answer.status = STATUS_FULL;
            else list_words.insert(int'(index), value);
         end
      endcase
      answer.count    = COUNT_W'(list_words.size());
      answer.is_empty = (list_words.size() == 0);
      expected_answers.insert(expected_answers.size(), answer);
   endfunction

   // Offer one request word after a random gap and wait until it is taken.
   // The valid line is only lowered when a gap is drawn, so a word that
   // follows straight on never sees valid dropped and raised in one step.
   task automatic send_word(input mode_type mode, input logic [INDEX_W-1:0] index,
                            input logic [WORD_W-1:0] value);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= {1'b0, value, index};
      do @(posedge clock); while (!req_tready);
      predict_answer(mode, index, value);
   endtask

   // Stop offering and let every outstanding answer come back.
   task automatic wait_for_answers();
      req_tvalid <= 1'b0;
      while (expected_answers.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic logic [WORD_W-1:0] random_word();
      case ($urandom_range(0, 9))
         0:       return '0;
         1:       return '1;
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // Requests against an empty and a short list: reads, erases and inserts
   // outside the count, inserts at the head, in the middle and at the end,
   // and erases at the head, in the middle and of the last element.
   task automatic test_short_list();
      send_word(MODE_READ,   7'd0,   64'h0123_4567_89AB_CDEF);
      send_word(MODE_READ,   7'd127, '0);
      send_word(MODE_ERASE,  7'd0,   '0);
      send_word(MODE_ERASE,  7'd127, '1);
      send_word(MODE_INSERT, 7'd1,   '1);
      send_word(MODE_INSERT, 7'd127, '1);
      send_word(MODE_INSERT, 7'd0,   '0);
      send_word(MODE_APPEND, 7'd127, '1);
      send_word(MODE_INSERT, 7'd1,   64'hA5A5_5A5A_F00F_0FF0);
      send_word(MODE_INSERT, 7'd3,   64'h8000_0000_0000_0001);
      send_word(MODE_READ,   7'd0,   '0);
      send_word(MODE_READ,   7'd1,   '0);
      send_word(MODE_READ,   7'd3,   '0);
      send_word(MODE_READ,   7'd4,   '0);
      send_word(MODE_ERASE,  7'd1,   '0);
      send_word(MODE_ERASE,  7'd5,   '0);
      send_word(MODE_ERASE,  7'd2,   '0);
      send_word(MODE_INSERT, 7'd4,   '1);
      send_word(MODE_ERASE,  7'd0,   '0);
      send_word(MODE_READ,   7'd0,   '0);
   endtask

   // Fill the store to capacity, then push at both limits: appends and
   // inserts on a full store, an insert past the count, reads and erases at
   // and beyond the last element.
   task automatic test_full_store();
      while (list_words.size() < CAPACITY) send_word(MODE_APPEND, 7'd0, random_word());
      send_word(MODE_APPEND, 7'd0,  '1);
      send_word(MODE_INSERT, 7'd64, '1);
      send_word(MODE_INSERT, 7'd0,  '1);
      send_word(MODE_INSERT, 7'd65, '1);
      send_word(MODE_READ,   7'd63, '0);
      send_word(MODE_READ,   7'd64, '0);
      send_word(MODE_ERASE,  7'd64, '0);
      send_word(MODE_ERASE,  7'd63, '0);
      send_word(MODE_INSERT, 7'd63, 64'hFFFF_0000_FFFF_0000);
      send_word(MODE_ERASE,  7'd0,  '0);
   endtask

   // Mostly well-formed requests with random content. A target fill level
   // wanders between empty and full so that the list spends time at both
   // ends; a small share of words is pure noise or aimed outside the count.
   task automatic test_random_traffic(input int items);
      int                 target;
      int                 held;
      int                 roll;
      mode_type           mode;
      logic [INDEX_W-1:0] index;
      target = $urandom_range(0, CAPACITY);
      for (int k = 0; k < items; k++) begin
         if ($urandom_range(0, 39) == 0) begin
            if ($urandom_range(0, 2) == 0) target = $urandom_range(0, 1) * CAPACITY;
            else target = $urandom_range(0, CAPACITY);
         end
         steady_flow = (k % 60) >= 45;
         held = list_words.size();
         roll = $urandom_range(0, 99);
         if (roll < 6) begin
            mode  = mode_type'($urandom_range(0, 3));
            index = INDEX_W'($urandom_range(0, 127));
         end else begin
            roll = $urandom_range(0, 99);
            if (held < target) begin
               if (roll < 35) mode = MODE_APPEND;
               else if (roll < 65) mode = MODE_INSERT;
               else if (roll < 90) mode = MODE_READ;
               else mode = MODE_ERASE;
            end else begin
               if (roll < 40) mode = MODE_ERASE;
               else if (roll < 70) mode = MODE_READ;
               else if (roll < 85) mode = MODE_INSERT;
               else mode = MODE_APPEND;
            end
            if ($urandom_range(0, 19) == 0)
               index = INDEX_W'($urandom_range(held, 127));
            else if (mode == MODE_INSERT)
               index = INDEX_W'($urandom_range(0, held));
            else
               index = (held == 0) ? '0 : INDEX_W'($urandom_range(0, held - 1));
         end
         send_word(mode, index, random_word());
      end
      steady_flow = 1'b0;
   endtask

   // The receiver stops taking answers for a long spell while requests keep
   // coming back to back, so the block must fill up and drop req_tready.
   task automatic test_back_pressure();
      wait_for_answers();
      steady_flow  = 1'b1;
      hold_request = HOLD_OFF_CYCLES;
      for (int k = 0; k < 20; k++) begin
         if (k % 3 == 0) send_word(MODE_READ, INDEX_W'($urandom_range(0, 70)), '0);
         else if (k % 3 == 1) send_word(MODE_INSERT, INDEX_W'($urandom_range(0, 20)),
                                        random_word());
         else send_word(MODE_ERASE, INDEX_W'($urandom_range(0, 20)), '0);
      end
      steady_flow = 1'b0;
      wait_for_answers();
   endtask

   // Receiver: before each answer word it draws a stall, and it honours a
   // long hold-off when one is asked for, counting the cycles itself.
   initial begin
      int stall;
      rsp_tready <= 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         if (hold_request > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_request) @(posedge clock);
            hold_request = 0;
         end else begin
            stall = steady_flow ? 0 : $urandom_range(0, 4);
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
      end
   end

   // Checker: compares each answer word taken from the block with the oldest
   // prediction, and counts the cycles in which nothing moves.
   always @(posedge clock) begin
      list_answer_type want;
      if (reset) begin
         quiet_cycles <= 0;
      end else begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_answers.size() == 0) begin
               $error("answer word %h arrived with no request outstanding", rsp_tdata);
               mismatches++;
            end else begin
               want = expected_answers.pop_front();
               if (rsp_tdata[63:0] !== want.read_data) begin
                  $error("read_data: expected %h, actual %h", want.read_data,
                         rsp_tdata[63:0]);
                  mismatches++;
               end
               if (rsp_tdata[65:64] !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_tdata[65:64]);
                  mismatches++;
               end
               if (rsp_tdata[72:66] !== want.count) begin
                  $error("count: expected %0d, actual %0d", want.count, rsp_tdata[72:66]);
                  mismatches++;
               end
               if (rsp_tdata[73] !== want.is_empty) begin
                  $error("is_empty: expected %0d, actual %0d", want.is_empty, rsp_tdata[73]);
                  mismatches++;
               end
            end
         end
      end
   end

   // Watchdog: a run in which nothing moves for too long has hung.
   initial begin
      do @(posedge clock); while (quiet_cycles < WATCHDOG_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= '0;
      req_tdata  <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_short_list();
      test_full_store();
      test_random_traffic(200);
      test_back_pressure();
      test_random_traffic(220);
      wait_for_answers();

      // Give a stray late word time to show up before the verdict.
      repeat (8) @(posedge clock);
      if (mismatches == 0 && expected_answers.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/ilie_pkg.sv
rtl/ilie_cell.sv
rtl/indexed_list_insert_erase_top.sv
tb/tb.sv
